// ----- rtl/core/arpc_pkg.sv -----
// Shared types and constants for the ARP cache and responder.
// Holds the transaction structs and the protocol and cache-action codes.
// No dependencies.
`timescale 1ns / 1ps

package arpc_pkg;

   // ARP field codes, host order
   localparam logic [15:0] HW_ETHERNET = 16'h0001;
   localparam logic [15:0] PROTO_IPV4  = 16'h0800;
   localparam logic [15:0] OP_REQUEST  = 16'h0001;
   localparam logic [15:0] OP_REPLY    = 16'h0002;

   // Cache actions reported with each result
   localparam logic [1:0] ACT_NONE      = 2'd0;
   localparam logic [1:0] ACT_REFRESH   = 2'd1;
   localparam logic [1:0] ACT_FILL      = 2'd2;
   localparam logic [1:0] ACT_OVERWRITE = 2'd3;

   localparam int SLOT_W = 5;

   typedef struct packed {
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [15:0] op_code;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [31:0] target_ip;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [1:0]        cache_action;
      logic [SLOT_W-1:0] cache_slot;
      logic              send_reply;
      logic [47:0]       reply_mac;
      logic [31:0]       reply_ip;
      logic              reply_for_us;
   } rsp_type;

   // Classified packet handed from the front to the back
   typedef struct packed {
      logic        learn;
      logic        send_reply;
      logic        reply_for_us;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
   } cmd_type;

endpackage

// ----- rtl/core/arpc_front.sv -----
// Front end: own-IP register, packet classification and a two-entry command queue.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  arpc_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output arpc_pkg::cmd_type cmd_data
);

   logic [31:0]       own_ip_ff;
   arpc_pkg::cmd_type cls;
   logic              type_ok;
   logic              for_us;
   arpc_pkg::cmd_type queue_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;

   // Hold the interface address
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= 32'd0;
      end else if (csr_wr_en) begin
         own_ip_ff <= csr_wr_data;
      end
   end

   // Classify the incoming packet
   always_comb begin
      type_ok = (req_data.hw_type == arpc_pkg::HW_ETHERNET) &&
                (req_data.proto_type == arpc_pkg::PROTO_IPV4);
      for_us  = type_ok && (req_data.target_ip == own_ip_ff);
      cls.learn        = type_ok;
      cls.send_reply   = for_us && (req_data.op_code == arpc_pkg::OP_REQUEST);
      cls.reply_for_us = for_us && (req_data.op_code == arpc_pkg::OP_REPLY);
      cls.sender_mac   = req_data.sender_mac;
      cls.sender_ip    = req_data.sender_ip;
   end

   // Queue control
   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified transaction
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/core/arpc_back.sv -----
// Back end: ARP cache (valid bits and IP per entry), match and write-back,
// and the result register. Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_back #(
   parameter int CACHE_ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  arpc_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output arpc_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CACHE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

   // Lowest set bit of a vector
   function automatic logic [IDX_W-1:0] first_set(input logic [CACHE_ENTRIES-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = IDX_W'(i);
         end
      end
      return r;
   endfunction

   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]              entry_ip_ff [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] hit_ff;
   logic [CACHE_ENTRIES-1:0] free_ff;
   arpc_pkg::cmd_type        cmd_ff;
   logic                     busy_ff, busy_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   arpc_pkg::rsp_type        rsp_ff;
   arpc_pkg::rsp_type        rsp_in;
   logic                     pop;
   logic                     commit;
   logic                     any_hit;
   logic                     any_free;
   logic [IDX_W-1:0]         wr_idx;
   logic                     wr_en;

   // One transaction in flight: compare on pop, write back on commit
   assign cmd_ready = !busy_ff;
   assign pop       = cmd_valid && !busy_ff;
   assign commit    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign busy_in   = pop || (busy_ff && !commit);

   // Compare the sender IP against every entry
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff  <= cmd_data;
         free_ff <= ~valid_ff;
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            hit_ff[i] <= valid_ff[i] && (entry_ip_ff[i] == cmd_data.sender_ip);
         end
      end
   end

   // Pick the entry to write
   always_comb begin
      any_hit  = |hit_ff;
      any_free = |free_ff;
      if (any_hit) begin
         wr_idx = first_set(hit_ff);
      end else if (any_free) begin
         wr_idx = first_set(free_ff);
      end else begin
         wr_idx = LAST_IDX;
      end
      wr_en = commit && cmd_ff.learn && !any_hit;

      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   // Build the result
   always_comb begin
      rsp_in = '0;
      if (cmd_ff.learn) begin
         rsp_in.accepted   = 1'b1;
         rsp_in.cache_slot = arpc_pkg::SLOT_W'(wr_idx);
         if (any_hit) begin
            rsp_in.cache_action = arpc_pkg::ACT_REFRESH;
         end else if (any_free) begin
            rsp_in.cache_action = arpc_pkg::ACT_FILL;
         end else begin
            rsp_in.cache_action = arpc_pkg::ACT_OVERWRITE;
         end
         rsp_in.reply_for_us = cmd_ff.reply_for_us;
         if (cmd_ff.send_reply) begin
            rsp_in.send_reply = 1'b1;
            rsp_in.reply_mac  = cmd_ff.sender_mac;
            rsp_in.reply_ip   = cmd_ff.sender_ip;
         end
      end
   end

   // Write the entry IP; the MAC of an entry has no reader here
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ip_ff[wr_idx] <= cmd_ff.sender_ip;
      end
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/arp_cache_and_responder.sv -----
// ARP cache and responder, top level. A request passes the queue register and
// then the compare/write-back stage before its result is valid. The back end takes
// a new transaction only after the last one has committed, set by the cache compare
// and write-back sequence. Synchronous active-high reset clears own IP to 0,
// empties the queue and marks every cache entry free in the same cycle.
`timescale 1ns / 1ps

module arp_cache_and_responder #(
   parameter int CACHE_ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  arpc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output arpc_pkg::rsp_type rsp_data
);

   logic              cmd_valid;
   logic              cmd_ready;
   arpc_pkg::cmd_type cmd_data;

   // Classify and queue
   arpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd_data    (cmd_data)
   );

   // Learn and respond
   arpc_back #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/core/arpc_checker.sv -----
// Port-level checks for the ARP cache and responder, bound to the top level.
// Depends on arpc_pkg and arp_cache_and_responder.
`timescale 1ns / 1ps

module arpc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input arpc_pkg::rsp_type rsp_data
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Dropped transaction carries no action
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |->
         rsp_data.cache_action == arpc_pkg::ACT_NONE && rsp_data.cache_slot == '0 &&
         !rsp_data.send_reply && !rsp_data.reply_for_us)
      else $error("dropped transaction reported an action");

   // Accepted transaction always reports a cache action
   a_learn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |-> rsp_data.cache_action != arpc_pkg::ACT_NONE)
      else $error("accepted transaction without cache action");

   // Reply address fields are clear unless a reply is ordered
   a_reply_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.send_reply |->
         rsp_data.reply_mac == '0 && rsp_data.reply_ip == '0)
      else $error("reply address set without reply order");

endmodule

bind arp_cache_and_responder arpc_checker u_arpc_checker (.*);

// ----- tb/sv/arp_cache_checker.sv -----
// Result checker for the ARP cache and responder: watches both channels and the
// register port, predicts each result and compares it field by field.
// Depends on arpc_pkg for the transaction structs and the protocol codes.
`timescale 1ns / 1ps

module arp_cache_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  arpc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  arpc_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);

   localparam int CACHE_DEPTH = 32;
   localparam int REPORT_MAX  = 10;

   // Shadow copy of the interface address and the cache
   logic [31:0] own_ip;
   logic        entry_known [CACHE_DEPTH];
   logic [31:0] known_ip    [CACHE_DEPTH];
   logic [47:0] known_mac   [CACHE_DEPTH];

   arpc_pkg::rsp_type expected_results [$];

   // Learn the sender pair into the shadow cache and work out the answer
   function automatic arpc_pkg::rsp_type learn_and_answer(input arpc_pkg::req_type pkt);
      arpc_pkg::rsp_type ans;
      int                slot;
      int                k;
      ans = '0;
      if (pkt.hw_type != arpc_pkg::HW_ETHERNET || pkt.proto_type != arpc_pkg::PROTO_IPV4)
         return ans;

      // refresh a valid entry that already holds the sender IP
      slot = -1;
      for (k = 0; k < CACHE_DEPTH; k++)
         if (slot < 0 && entry_known[k] && known_ip[k] == pkt.sender_ip)
            slot = k;
      if (slot >= 0) begin
         ans.cache_action = arpc_pkg::ACT_REFRESH;
      end else begin
         // take the lowest free entry, else overwrite the last one
         for (k = 0; k < CACHE_DEPTH; k++)
            if (slot < 0 && !entry_known[k])
               slot = k;
         if (slot >= 0) begin
            ans.cache_action = arpc_pkg::ACT_FILL;
         end else begin
            slot = CACHE_DEPTH - 1;
            ans.cache_action = arpc_pkg::ACT_OVERWRITE;
         end
         entry_known[slot] = 1'b1;
         known_ip[slot]    = pkt.sender_ip;
      end
      known_mac[slot] = pkt.sender_mac;

      ans.accepted   = 1'b1;
      ans.cache_slot = slot[arpc_pkg::SLOT_W-1:0];
      if (pkt.target_ip == own_ip) begin
         if (pkt.op_code == arpc_pkg::OP_REQUEST) begin
            ans.send_reply = 1'b1;
            ans.reply_mac  = pkt.sender_mac;
            ans.reply_ip   = pkt.sender_ip;
         end else if (pkt.op_code == arpc_pkg::OP_REPLY) begin
            ans.reply_for_us = 1'b1;
         end
      end
      return ans;
   endfunction

   // Compare returning transactions, then queue predictions for new ones
   always @(posedge clock) begin
      arpc_pkg::rsp_type want;
      if (reset) begin
         own_ip = '0;
         foreach (entry_known[k]) entry_known[k] = 1'b0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("%0t: result with nothing outstanding: %p", $realtime, rsp_data);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.accepted     !== want.accepted     ||
                   rsp_data.cache_action !== want.cache_action ||
                   rsp_data.cache_slot   !== want.cache_slot   ||
                   rsp_data.send_reply   !== want.send_reply   ||
                   rsp_data.reply_mac    !== want.reply_mac    ||
                   rsp_data.reply_ip     !== want.reply_ip     ||
                   rsp_data.reply_for_us !== want.reply_for_us) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("%0t: result mismatch", $realtime);
                     $display(
                        "   expected acc=%0d act=%0d slot=%0d reply=%0d mac=%h ip=%h us=%0d",
                        want.accepted, want.cache_action, want.cache_slot,
                        want.send_reply, want.reply_mac, want.reply_ip,
                        want.reply_for_us);
                     $display(
                        "   actual   acc=%0d act=%0d slot=%0d reply=%0d mac=%h ip=%h us=%0d",
                        rsp_data.accepted, rsp_data.cache_action, rsp_data.cache_slot,
                        rsp_data.send_reply, rsp_data.reply_mac, rsp_data.reply_ip,
                        rsp_data.reply_for_us);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(learn_and_answer(req_data));
         if (csr_wr_en)
            own_ip = csr_wr_data;
      end
      pending_count = expected_results.size();
   end

endmodule

// ----- tb/sv/tb_arp_cache_and_responder.sv -----
// Testbench top for the ARP cache and responder: clock, reset, packet and
// address stimulus, random stalls on both channels, and the final verdict.
// Depends on arpc_pkg, arp_cache_and_responder and arp_cache_checker.
`timescale 1ns / 1ps

module tb_arp_cache_and_responder;

   localparam int PHASES          = 5;
   localparam int PACKETS_PER_PHASE = 370;
   localparam int POOL_SIZE       = 48;
   localparam int CYCLE_LIMIT     = 200000;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [31:0]       csr_wr_data;
   logic              req_valid;
   logic              req_ready;
   arpc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   arpc_pkg::rsp_type rsp_data;

   int          fail_count;
   int          pending_count;
   int unsigned cycle_count = 0;
   bit          quiet = 1'b0;
   logic [31:0] own_ip_now;
   logic [31:0] ip_pool [POOL_SIZE];

   arp_cache_and_responder dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   arp_cache_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Stall the result channel at random unless in a quiet stretch
   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 24);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic arpc_pkg::req_type arp_packet(
      input logic [15:0] hw, input logic [15:0] proto,
      input logic [15:0] op, input logic [47:0] mac,
      input logic [31:0] sip, input logic [31:0] tip);
      arpc_pkg::req_type pkt;
      pkt.hw_type    = hw;
      pkt.proto_type = proto;
      pkt.op_code    = op;
      pkt.sender_mac = mac;
      pkt.sender_ip  = sip;
      pkt.target_ip  = tip;
      return pkt;
   endfunction

   // Mostly well-formed packets from a small address pool, some noise
   function automatic arpc_pkg::req_type random_packet();
      arpc_pkg::req_type pkt;
      int                roll;
      pkt.hw_type    = ($urandom_range(99) < 92) ? arpc_pkg::HW_ETHERNET : 16'($urandom);
      pkt.proto_type = ($urandom_range(99) < 92) ? arpc_pkg::PROTO_IPV4 : 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 40)
         pkt.op_code = arpc_pkg::OP_REQUEST;
      else if (roll < 80)
         pkt.op_code = arpc_pkg::OP_REPLY;
      else
         pkt.op_code = 16'($urandom);
      pkt.sender_mac = {16'($urandom), 32'($urandom)};
      pkt.sender_ip  = ($urandom_range(99) < 85) ? ip_pool[$urandom_range(POOL_SIZE - 1)]
                                                 : 32'($urandom);
      roll = $urandom_range(99);
      if (roll < 45)
         pkt.target_ip = own_ip_now;
      else if (roll < 60)
         pkt.target_ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
      else
         pkt.target_ip = 32'($urandom);
      return pkt;
   endfunction

   // Offer one packet after a random gap and hold it until accepted
   task automatic send_packet(input arpc_pkg::req_type pkt);
      while (!quiet && $urandom_range(99) < 24) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = pkt;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Hold off until every result is back, then change the interface address
   task automatic set_own_ip(input logic [31:0] ip);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = ip;
      own_ip_now  = ip;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      logic [31:0] phase_ip;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_data    = '0;
      own_ip_now  = '0;
      foreach (ip_pool[k]) ip_pool[k] = $urandom;
      ip_pool[0] = '0;
      ip_pool[1] = '1;

      repeat (7) @(negedge clock);
      reset = 1'b0;

      // drop packets that fail the type checks, byte-swapped codes included
      send_packet(arp_packet(16'hFFFF, arpc_pkg::PROTO_IPV4, arpc_pkg::OP_REQUEST,
                             '1, '1, '0));
      send_packet(arp_packet(arpc_pkg::HW_ETHERNET, 16'h0000, arpc_pkg::OP_REQUEST,
                             '1, '1, '0));
      send_packet(arp_packet(16'h0000, 16'hFFFF, arpc_pkg::OP_REPLY, '0, '0, '0));
      send_packet(arp_packet(16'h0100, arpc_pkg::PROTO_IPV4, arpc_pkg::OP_REQUEST,
                             48'h1, 32'h1, '0));
      send_packet(arp_packet(arpc_pkg::HW_ETHERNET, 16'h0008, arpc_pkg::OP_REPLY,
                             48'h1, 32'h1, '0));

      // own address still zero: target zero is addressed to us
      send_packet(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                             arpc_pkg::OP_REQUEST, '0, '0, '0));
      send_packet(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                             arpc_pkg::OP_REPLY, '1, '1, '0));
      send_packet(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, 16'hFFFF,
                             48'h0123_4567_89AB, 32'h0A00_0001, '0));
      send_packet(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, 16'h0000,
                             48'h0123_4567_89AC, 32'h0A00_0002, '0));

      // refresh known senders, targets elsewhere
      send_packet(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                             arpc_pkg::OP_REQUEST,
                             48'hAAAA_5555_AAAA, '0, 32'h0000_0001));
      send_packet(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                             arpc_pkg::OP_REPLY,
                             48'h5555_AAAA_5555, '1, '1));
      send_packet(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                             arpc_pkg::OP_REQUEST,
                             48'h0123_4567_89AB, 32'h0A00_0001, 32'h8000_0000));

      // random phases, each under its own interface address: all ones, random, zero, random, then a pool entry
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       phase_ip = '1;
            2:       phase_ip = '0;
            4:       phase_ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
            default: phase_ip = $urandom;
         endcase
         set_own_ip(phase_ip);
         quiet = (phase == 2);
         repeat (PACKETS_PER_PHASE) send_packet(random_packet());
      end

      // drain and settle
      req_valid = 1'b0;
      quiet     = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/arpc_pkg.sv
rtl/core/arpc_front.sv
rtl/core/arpc_back.sv
rtl/core/arp_cache_and_responder.sv
rtl/core/arpc_checker.sv
tb/sv/arp_cache_checker.sv
tb/sv/tb_arp_cache_and_responder.sv
